FILE: design/smtpds_pkg.sv
// Package for the SMTP body dot stuffer: item types, character codes,
// mode codes and the code page translation. No dependencies.
package smtpds_pkg;

  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_DOT = 8'd46;

  // body_mode codes; the unused code behaves as MODE_XLATE (bit 1 = translate)
  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_STUFF = 2'd1;
  localparam logic [1:0] MODE_XLATE = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // one or two encoded bytes for one input item
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       two;
  } enc_t;

  // DOS code page umlauts and sharp s to Latin-1
  function automatic logic [7:0] translate_byte(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      8'd129:  r = 8'd252;
      8'd132:  r = 8'd228;
      8'd142:  r = 8'd196;
      8'd148:  r = 8'd246;
      8'd153:  r = 8'd214;
      8'd154:  r = 8'd220;
      8'd225:  r = 8'd223;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

FILE: design/smtpds_encoder.sv
// Byte encoder: CRLF normalization, dot stuffing and umlaut translation.
// Depends on smtpds_pkg.
module smtpds_encoder (
  input  logic [7:0]        data_byte,
  input  logic [7:0]        prev_byte,
  input  logic [1:0]        body_mode,
  output smtpds_pkg::enc_t  enc
);
  import smtpds_pkg::*;

  always_comb begin
    enc.first  = data_byte;
    enc.second = data_byte;
    enc.two    = 1'b0;
    if (body_mode != MODE_PASS) begin
      if (data_byte == CH_LF) begin
        if (prev_byte != CH_CR) begin
          // lone LF -> CR LF
          enc.first = CH_CR;
          enc.two   = 1'b1;
        end
      end else if (data_byte == CH_DOT && prev_byte == CH_LF) begin
        enc.two = 1'b1;
      end else if (body_mode[1]) begin
        enc.first = translate_byte(data_byte);
      end
    end
  end

endmodule

FILE: design/smtp_body_dot_stuffer.sv
// SMTP body encoder top level: input register, encoder, result register.
// An accepted item goes through the input register, then the result register.
// Up to one input item per cycle while dn_stall is low; an item that expands to
//   two bytes holds the result register until both leave by the one output port.
// Reset (rst, synchronous): both stages empty, body_mode = 1, previous byte = LF.
// Depends on smtpds_pkg and smtpds_encoder.
module smtp_body_dot_stuffer (
  input  logic                   clk,
  input  logic                   rst,
  // upstream byte channel
  input  logic                   up_valid,
  output logic                   up_stall,
  input  smtpds_pkg::in_item_t   up_item,
  // downstream encoded byte channel
  output logic                   dn_valid,
  input  logic                   dn_stall,
  output smtpds_pkg::out_item_t  dn_item,
  // body_mode register write
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_wdata
);
  import smtpds_pkg::*;

  logic [1:0] body_mode;
  logic [7:0] prev_raw;        // last raw data byte accepted

  // input stage: raw byte plus the previous byte as the encoder must see it
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic [7:0] s1_prev;

  // result stage: one or two encoded bytes, phase marks the second one
  logic       ob_valid;
  enc_t       ob_enc;
  logic       ob_phase;

  enc_t       enc;
  logic       up_fire;
  logic       dn_fire;
  logic       ob_done;         // last byte of the held run leaves this cycle
  logic       ob_free;
  logic       move;            // input stage hands its item to the result stage

  smtpds_encoder u_enc (
    .data_byte (s1_byte),
    .prev_byte (s1_prev),
    .body_mode (body_mode),
    .enc       (enc)
  );

  // output mux: first byte, then the second byte if the run has two
  always_comb begin
    dn_valid            = ob_valid;
    dn_item.out_byte    = ob_phase ? ob_enc.second : ob_enc.first;
    dn_item.last_of_run = ob_phase | ~ob_enc.two;
  end

  assign dn_fire  = ob_valid & ~dn_stall;
  assign ob_done  = dn_fire & dn_item.last_of_run;
  assign ob_free  = ~ob_valid | ob_done;
  assign move     = s1_valid & ob_free;
  // input register frees up when it is empty or moving on this cycle
  assign up_stall = s1_valid & ~ob_free;
  assign up_fire  = up_valid & ~up_stall;

  // configuration register, written by the user only while idle; not enforced
  always_ff @(posedge clk) begin
    if (rst) begin
      body_mode <= MODE_STUFF;
    end else if (cfg_we) begin
      body_mode <= cfg_wdata;
    end
  end

  // input stage; message_start forces the history to LF for this byte
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      prev_raw <= CH_LF;
    end else begin
      if (up_fire) begin
        s1_valid <= 1'b1;
        prev_raw <= up_item.data_byte;
      end else if (move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_fire) begin
      s1_byte <= up_item.data_byte;
      s1_prev <= up_item.message_start ? CH_LF : prev_raw;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      ob_phase <= 1'b0;
    end else begin
      if (move) begin
        ob_valid <= 1'b1;
        ob_phase <= 1'b0;
      end else if (ob_done) begin
        ob_valid <= 1'b0;
        ob_phase <= 1'b0;
      end else if (dn_fire) begin
        // first byte of a two byte run taken
        ob_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      ob_enc <= enc;
    end
  end

endmodule

FILE: design/smtpds_checker.sv
// Port level checks for smtp_body_dot_stuffer, bound to the top level.
// Depends on smtpds_pkg.
module smtpds_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   dn_valid,
  input logic                   dn_stall,
  input smtpds_pkg::out_item_t  dn_item
);
  import smtpds_pkg::*;

  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    dn_valid && dn_stall |=> dn_valid)
    else $error("result valid dropped while stalled");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    dn_valid && dn_stall |=> $stable(dn_item))
    else $error("stalled result item changed");

  // a two byte run never splits: its last byte follows at once
  a_run_closes: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !dn_stall && !dn_item.last_of_run |=> dn_valid && dn_item.last_of_run)
    else $error("second byte of run missing");

  // only a CR insertion or a stuffed dot opens a two byte run
  a_run_head: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !dn_item.last_of_run |->
      dn_item.out_byte == CH_CR || dn_item.out_byte == CH_DOT)
    else $error("unexpected first byte of run");

endmodule

bind smtp_body_dot_stuffer smtpds_checker u_smtpds_checker (
  .clk      (clk),
  .rst      (rst),
  .dn_valid (dn_valid),
  .dn_stall (dn_stall),
  .dn_item  (dn_item)
);

FILE: bench/tb_smtp_body_dot_stuffer.sv
`timescale 1ns / 1ps
// Testbench for smtp_body_dot_stuffer: directed and random body bytes in every mode,
// checked against an in-bench encoder model. Depends on smtpds_pkg and the RTL only.
module tb_smtp_body_dot_stuffer;
  import smtpds_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int RST_CYCLES = 8;
  // the top level documents no meaning for mode 3; the encoder treats it like translate
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // long downstream hold used to fill the pipe and push stall back to the sender
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_WAIT = 18;
  // pipe is 2 deep, so a handful of idle cycles is plenty once the queue is empty
  localparam int DRAIN_CYCLES = 10;
  // overall time limit for the run, in ns
  localparam int LIMIT_NS = 2_000_000;
  localparam int PRINT_CAP = 30;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      up_valid = 1'b0;
  logic      up_stall;
  in_item_t  up_item = '0;
  logic      dn_valid;
  logic      dn_stall = 1'b0;
  out_item_t dn_item;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;

  // encoder model state
  logic [1:0] mode_q;
  logic [7:0] prev_raw;

  out_item_t expected_bytes[$];
  out_item_t want;

  int  err_count = 0;
  int  items_sent = 0;
  int  bytes_out = 0;
  int  msg_starts = 0;
  int  rx_wait = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  hold_req = 1'b0;
  logic long_hold = 1'b0;

  smtp_body_dot_stuffer dut (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (up_valid),
    .up_stall  (up_stall),
    .up_item   (up_item),
    .dn_valid  (dn_valid),
    .dn_stall  (dn_stall),
    .dn_item   (dn_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Encoder model
  // ---------------------------------------------------------------

  // DOS umlauts and sharp s to their Latin-1 codes
  function automatic logic [7:0] dos_to_latin1(input logic [7:0] b);
    case (b)
      8'd129:  return 8'd252;
      8'd132:  return 8'd228;
      8'd142:  return 8'd196;
      8'd148:  return 8'd246;
      8'd153:  return 8'd214;
      8'd154:  return 8'd220;
      8'd225:  return 8'd223;
      default: return b;
    endcase
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic last);
    out_item_t e;
    e.out_byte    = b;
    e.last_of_run = last;
    expected_bytes.push_back(e);
  endtask

  // Works out the one or two encoded bytes for an accepted body byte.
  task automatic encode_body_byte(input logic [7:0] b, input logic start);
    logic [7:0] seen;
    seen = start ? CH_LF : prev_raw;
    // history always keeps the raw byte, whatever went out
    prev_raw = b;
    if (mode_q == MODE_PASS) begin
      queue_byte(b, 1'b1);
    end else if (b == CH_LF) begin
      if (seen == CH_CR) begin
        queue_byte(CH_LF, 1'b1);
      end else begin
        // lone LF goes out as CR LF
        queue_byte(CH_CR, 1'b0);
        queue_byte(CH_LF, 1'b1);
      end
    end else if (b == CH_DOT && seen == CH_LF) begin
      // dot at line start is doubled
      queue_byte(CH_DOT, 1'b0);
      queue_byte(CH_DOT, 1'b1);
    end else begin
      // bit 1 of the mode enables translation, so the unused code translates too
      queue_byte(mode_q[1] ? dos_to_latin1(b) : b, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------

  function automatic int draw_wait(input bit on);
    if (!on || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Offers one body byte and returns at the edge where it was taken. Valid stays
  // high on return so back-to-back items never lower and raise it in one step.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    in_item_t it;
    gap = draw_wait(tx_idle_on);
    if (gap > 0) begin
      up_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.data_byte     = b;
    it.message_start = start;
    up_item  <= it;
    up_valid <= 1'b1;
    @(posedge clk);
    while (up_stall) @(posedge clk);
    encode_body_byte(b, start);
    items_sent++;
    if (start) msg_starts++;
  endtask

  // Stop offering and wait until every predicted byte has come out.
  task automatic drain;
    up_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Mode changes only with the pipe empty.
  task automatic set_mode(input logic [1:0] m);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_q = m;
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (err_count < PRINT_CAP)
      $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, exp_val);
    err_count++;
  endtask

  // ---------------------------------------------------------------
  // Downstream side: random stall per item, plus the long hold
  // ---------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      dn_stall <= 1'b0;
      rx_wait = 0;
    end else if (long_hold) begin
      dn_stall <= 1'b1;
    end else if (dn_valid && !dn_stall) begin
      rx_wait = draw_wait(rx_idle_on);
      dn_stall <= (rx_wait != 0);
    end else if (rx_wait != 0) begin
      rx_wait--;
      dn_stall <= (rx_wait != 0);
    end else begin
      dn_stall <= 1'b0;
    end
  end

  // Long hold, counted here so the sender keeps offering meanwhile.
  initial begin
    forever begin
      wait (hold_req);
      @(posedge clk);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      long_hold <= 1'b0;
      hold_req = 1'b0;
    end
  end

  // Result checker: each taken byte against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && dn_valid && !dn_stall) begin
      bytes_out++;
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", int'(dn_item.out_byte), -1);
      end else begin
        want = expected_bytes.pop_front();
        if (dn_item.out_byte !== want.out_byte)
          report_mismatch("out_byte", int'(dn_item.out_byte), int'(want.out_byte));
        if (dn_item.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", int'(dn_item.last_of_run),
                          int'(want.last_of_run));
      end
    end
  end

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------

  // Reset mode is dot-stuff; no write first, so the reset value is checked too.
  task automatic test_stuffing;
    send_byte(CH_DOT, 1'b0);   // history is LF out of reset
    send_byte("a", 1'b0);
    send_byte(CH_LF, 1'b0);    // lone LF
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);    // LF after CR passes
    send_byte(CH_DOT, 1'b0);   // doubled
    send_byte(CH_DOT, 1'b0);   // not doubled
    send_byte(CH_DOT, 1'b1);   // message start forces LF history
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b1);    // start overrides the CR
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_translate;
    set_mode(MODE_XLATE);
    send_byte(8'd129, 1'b0);
    send_byte(8'd132, 1'b0);
    send_byte(8'd142, 1'b0);
    send_byte(8'd148, 1'b0);
    send_byte(8'd153, 1'b0);
    send_byte(8'd154, 1'b0);
    send_byte(8'd225, 1'b0);
    send_byte(8'd128, 1'b0);   // neighbor, not in the table
    set_mode(MODE_UNUSED);
    send_byte(8'd153, 1'b0);
  endtask

  // Pass mode sends raw but still tracks history: LF taken in pass mode
  // must make the next dot double once stuffing is back on.
  task automatic test_pass_through;
    set_mode(MODE_PASS);
    send_byte(CH_DOT, 1'b1);
    send_byte(8'd129, 1'b0);
    send_byte(CH_LF, 1'b0);
    set_mode(MODE_STUFF);
    send_byte(CH_DOT, 1'b0);
  endtask

  function automatic logic [7:0] pick_body_byte;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: return 8'd129;
          1: return 8'd132;
          2: return 8'd142;
          3: return 8'd148;
          4: return 8'd153;
          5: return 8'd154;
          default: return 8'd225;
        endcase
      end
      1: return CH_CR;
      2: return CH_DOT;
      3: return CH_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends about n items as messages of lines, with some raw noise mixed in.
  task automatic send_random_bodies(input int n);
    int left;
    int line_len;
    int k;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 6) == 0) begin
        // noise: arbitrary bytes, start flag at random
        repeat (8) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
          left--;
        end
      end else begin
        send_byte(pick_body_byte(), 1'b1);
        left--;
        for (k = 0; k < $urandom_range(1, 5) && left > 0; k++) begin
          if ($urandom_range(0, 4) < 2) begin
            send_byte(CH_DOT, 1'b0);
            left--;
          end
          line_len = $urandom_range(0, 10);
          repeat (line_len) begin
            send_byte(pick_body_byte(), 1'b0);
            left--;
          end
          case ($urandom_range(0, 9))
            0: begin
              send_byte(CH_CR, 1'b0);
              left--;
            end
            1, 2, 3, 4: begin
              send_byte(CH_LF, 1'b0);
              left--;
            end
            default: begin
              send_byte(CH_CR, 1'b0);
              send_byte(CH_LF, 1'b0);
              left -= 2;
            end
          endcase
        end
      end
    end
  endtask

  task automatic test_random_modes;
    logic [1:0] plan [8];
    int p;
    plan = '{MODE_STUFF, MODE_XLATE, MODE_PASS, MODE_UNUSED,
             MODE_XLATE, MODE_STUFF, MODE_PASS, MODE_XLATE};
    for (p = 0; p < 8; p++) begin
      set_mode(plan[p]);
      // phase 1 idles neither side, phase 2 only the sender, phase 3 only the receiver
      tx_idle_on = (p != 1) && (p != 3);
      rx_idle_on = (p != 1) && (p != 2);
      send_random_bodies(85);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Receiver holds off while the sender streams, so the block must stall its input.
  task automatic test_backpressure;
    int k;
    set_mode(MODE_XLATE);
    tx_idle_on = 1'b0;
    hold_req = 1'b1;
    for (k = 0; k < 40; k++) send_byte(pick_body_byte(), 1'(k == 0));
    drain();
    tx_idle_on = 1'b1;
  endtask

  initial begin
    mode_q   = MODE_STUFF;
    prev_raw = CH_LF;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_stuffing();
    test_translate();
    test_pass_through();
    test_random_modes();
    test_backpressure();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0)
      report_mismatch("bytes never delivered", 0, expected_bytes.size());

    $display("run covered %0d body bytes (%0d message starts), %0d encoded bytes out,",
             items_sent, msg_starts, bytes_out);
    $display("all four mode codes, random idling on both sides and a long output hold");
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d bytes still expected", expected_bytes.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
